>>> hw/rtl/ihc_pkg.sv
// shared types, constants and verdict codes for the ipv4 header ingress checker
// no dependencies; imported by every module of the block
package ihc_pkg;

  // link and ip header limits
  localparam int LINK_HEADER_BYTES   = 14;
  localparam int MIN_IP_HEADER_BYTES = 20;

  // stream widths
  localparam int IN_DATA_W    = 32;
  localparam int IN_USER_W    = 2;
  localparam int OUT_FIELDS_W = 34;
  localparam int OUT_DATA_W   = 40;

  // verdict codes
  localparam logic [2:0] VERDICT_OK           = 3'd0;
  localparam logic [2:0] VERDICT_OTHER_HOST   = 3'd1;
  localparam logic [2:0] VERDICT_TOO_SMALL    = 3'd2;
  localparam logic [2:0] VERDICT_NOT_V4       = 3'd3;
  localparam logic [2:0] VERDICT_SHORT_HEADER = 3'd4;
  localparam logic [2:0] VERDICT_CHECKSUM     = 3'd5;
  localparam logic [2:0] VERDICT_LENGTH       = 3'd6;
  localparam logic [2:0] VERDICT_TRUNCATED    = 3'd7;

  // header word positions and field values
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [4:0]  TOTAL_LEN_WORD = 5'd1;
  localparam logic [4:0]  PROTOCOL_WORD  = 5'd4;
  localparam logic [15:0] CHECKSUM_GOOD  = 16'hffff;

  // per-packet state; acc is a one's-complement sum with end-around carry
  typedef struct packed {
    logic [15:0] acc;
    logic [4:0]  word_count;
    logic [5:0]  header_len;
    logic [15:0] total_len;
    logic [15:0] frame_len;
    logic [7:0]  protocol;
    logic        idle;
  } ihc_state_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
    logic        last_word;
    logic [15:0] frame_bytes;
    logic        for_other_host;
  } ihc_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
    logic        needs_trim;
    logic [7:0]  protocol_number;
  } ihc_result_t;

endpackage

>>> hw/rtl/ihc_step.sv
// per-word header checking logic: next packet state and optional verdict
// depends on ihc_pkg
module ihc_step (
  input  ihc_pkg::ihc_state_t  state_i,
  input  ihc_pkg::ihc_item_t   item_i,
  output ihc_pkg::ihc_state_t  state_o,
  output logic                 emit_o,
  output ihc_pkg::ihc_result_t result_o
);
  import ihc_pkg::*;

  always_comb begin
    ihc_state_t  base;
    logic        go;
    logic [2:0]  verdict;
    logic [16:0] acc_sum;
    logic [15:0] acc_fold;
    logic [16:0] frame_limit;
    logic [4:0]  wc_next;
    logic [5:0]  ihl_bytes;

    base        = state_i;
    go          = 1'b0;
    emit_o      = 1'b0;
    verdict     = VERDICT_OK;
    acc_sum     = '0;
    acc_fold    = '0;
    wc_next     = '0;
    ihl_bytes   = {item_i.header_word[11:8], 2'b00};

    // first word: fresh packet, early checks in priority order
    if (item_i.first_word) begin
      base.acc        = '0;
      base.word_count = '0;
      base.header_len = '0;
      base.total_len  = '0;
      base.protocol   = '0;
      base.frame_len  = item_i.frame_bytes;
      base.idle       = 1'b0;
      if (item_i.for_other_host) begin
        emit_o  = 1'b1;
        verdict = VERDICT_OTHER_HOST;
      end else if (item_i.frame_bytes < 16'(LINK_HEADER_BYTES + MIN_IP_HEADER_BYTES)) begin
        emit_o  = 1'b1;
        verdict = VERDICT_TOO_SMALL;
      end else if (item_i.header_word[15:12] != IPV4_VERSION) begin
        emit_o  = 1'b1;
        verdict = VERDICT_NOT_V4;
      end else begin
        base.header_len = ihl_bytes;
        if (ihl_bytes < 6'(MIN_IP_HEADER_BYTES)) begin
          emit_o  = 1'b1;
          verdict = VERDICT_SHORT_HEADER;
        end else begin
          go = 1'b1;
        end
      end
    end else if (!state_i.idle) begin
      go = 1'b1;
    end

    state_o     = base;
    frame_limit = 17'(LINK_HEADER_BYTES) + {1'b0, base.total_len};

    if (go) begin
      if (base.word_count == TOTAL_LEN_WORD) begin
        state_o.total_len = item_i.header_word;
      end
      if (base.word_count == PROTOCOL_WORD) begin
        state_o.protocol = item_i.header_word[7:0];
      end
      // end-around carry keeps the folded sum in 16 bits
      acc_sum            = {1'b0, base.acc} + {1'b0, item_i.header_word};
      acc_fold           = acc_sum[15:0] + {15'd0, acc_sum[16]};
      state_o.acc        = acc_fold;
      wc_next            = base.word_count + 5'd1;
      state_o.word_count = wc_next;
      frame_limit        = 17'(LINK_HEADER_BYTES) + {1'b0, state_o.total_len};

      // header complete after header_len / 2 words
      if (wc_next == base.header_len[5:1]) begin
        emit_o = 1'b1;
        if (acc_fold != CHECKSUM_GOOD) begin
          verdict = VERDICT_CHECKSUM;
        end else if (state_o.total_len < {10'd0, base.header_len} ||
                     {1'b0, base.frame_len} < frame_limit) begin
          verdict = VERDICT_LENGTH;
        end else begin
          verdict = VERDICT_OK;
        end
      end else if (item_i.last_word) begin
        emit_o  = 1'b1;
        verdict = VERDICT_TRUNCATED;
      end
    end

    if (emit_o) begin
      state_o.idle = 1'b1;
    end

    result_o.verdict = verdict;
    if (verdict == VERDICT_OTHER_HOST || verdict == VERDICT_TOO_SMALL ||
        verdict == VERDICT_NOT_V4) begin
      result_o.header_bytes = '0;
    end else begin
      result_o.header_bytes = state_o.header_len;
    end
    result_o.total_length = state_o.total_len;
    if (verdict == VERDICT_OK) begin
      result_o.needs_trim      = ({1'b0, state_o.frame_len} > frame_limit);
      result_o.protocol_number = state_o.protocol;
    end else begin
      result_o.needs_trim      = 1'b0;
      result_o.protocol_number = '0;
    end
  end

endmodule

>>> hw/rtl/ipv4_header_ingress_checker.sv
// top level of the ipv4 header ingress checker: input register, checking step,
// result register; depends on ihc_pkg and ihc_step
//
// usage
//   input stream (in_*): one 16-bit ip header word per item, in network order.
//   the first word of a packet carries in_tuser[0] and, on that word only,
//   the ethernet frame length (in_tdata[31:16]) and the other-host flag
//   (in_tuser[1]). in_tlast marks the last word the link supplies.
//   result stream (out_*): at most one item per packet, the verdict together
//   with header length, total length, trim flag and protocol number.
//   a verdict is given on the word that decides it: the first word for the
//   early checks, the word completing the header (ihl*2 words) for checksum
//   and length, or in_tlast for a packet that ends too soon. words after the
//   verdict are dropped until the next first word.
// timing
//   out_tvalid rises once the deciding word has gone from the input register
//   through a single short combinational pass, the checking step, into the
//   result register. throughput is one word per cycle while out_tready keeps up.
// reset and stalls
//   reset empties both registers and leaves the block waiting for a first
//   word. while a result item waits on out_tready, the input register takes
//   at most one more word and then in_tready drops; nothing is lost or repeated.
module ipv4_header_ingress_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // header_word [15:0], frame_bytes [31:16]
  input  logic [ihc_pkg::IN_DATA_W-1:0]    in_tdata,
  // first_word [0], for_other_host [1]
  input  logic [ihc_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // verdict [2:0], header_bytes [8:3], total_length [24:9], needs_trim [25],
  // protocol_number [33:26], zero pad [39:34]
  output logic [ihc_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import ihc_pkg::*;

  logic        in_valid_r;
  ihc_item_t   in_item_r;
  ihc_state_t  state_r;
  ihc_state_t  state_nxt;
  logic        out_valid_r;
  ihc_result_t out_result_r;
  ihc_result_t result_nxt;
  logic        emit;
  logic        out_free;
  logic        fire;
  logic        in_accept;

  // result register can take a new item this cycle
  assign out_free  = !out_valid_r || out_tready;
  // the registered word is processed and leaves the input register
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_accept = in_tvalid && in_tready;

  ihc_step u_step (
    .state_i  (state_r),
    .item_i   (in_item_r),
    .state_o  (state_nxt),
    .emit_o   (emit),
    .result_o (result_nxt)
  );

  // control and packet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{idle: 1'b1, default: '0};
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= fire && emit;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r.header_word    <= in_tdata[15:0];
      in_item_r.frame_bytes    <= in_tdata[31:16];
      in_item_r.first_word     <= in_tuser[0];
      in_item_r.for_other_host <= in_tuser[1];
      in_item_r.last_word      <= in_tlast;
    end
    if (fire && emit) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                       out_result_r.protocol_number,
                       out_result_r.needs_trim,
                       out_result_r.total_length,
                       out_result_r.header_bytes,
                       out_result_r.verdict};

endmodule

>>> hw/rtl/ihc_checker.sv
// port-level checks for the ipv4 header ingress checker, bound to the top level
// depends on ihc_pkg and ipv4_header_ingress_checker
module ihc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ihc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ihc_pkg::*;

  // nothing comes out right after reset, and a word can be taken
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result valid or input blocked just after reset");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // early rejects carry no header length, trim flag or protocol number
  a_early_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == VERDICT_OTHER_HOST ||
                   out_tdata[2:0] == VERDICT_TOO_SMALL ||
                   out_tdata[2:0] == VERDICT_NOT_V4)
      |-> out_tdata[8:3] == 6'd0 && out_tdata[25] == 1'b0 && out_tdata[33:26] == 8'd0)
    else $error("early reject carries header fields");

  // an ok verdict has a sane header and total length
  a_ok_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == VERDICT_OK
      |-> out_tdata[8:3] >= 6'(MIN_IP_HEADER_BYTES) &&
          out_tdata[24:9] >= {10'd0, out_tdata[8:3]})
    else $error("ok verdict with bad lengths");

endmodule

bind ipv4_header_ingress_checker ihc_checker u_ihc_checker (.*);

>>> tb/sv/ipv4_header_ingress_checker_test.sv
// self-checking testbench for ipv4_header_ingress_checker: directed table then random packets,
// every result compared against a hand-written item or an in-bench header checker model
// depends on ihc_pkg and the ipv4_header_ingress_checker rtl
`timescale 1ns / 1ps

module ipv4_header_ingress_checker_test;
  import ihc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          RANDOM_WORDS  = 650;
  localparam int          MIN_FRAME     = LINK_HEADER_BYTES + MIN_IP_HEADER_BYTES;

  // one queued item; typed rows carry their verdict item written out by hand,
  // a hold entry makes the sender wait until all verdicts are back
  typedef struct packed {
    ihc_item_t   item;
    logic        typed;
    ihc_result_t want;
    logic        hold;
  } stim_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;

  ipv4_header_ingress_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  stim_t       stim_q[$];
  ihc_result_t verdict_q[$];
  stim_t       directed_rows [21];
  int          errors = 0;
  int          stim_words = 0;
  int unsigned cycle_count = 0;
  bit          mid_drained = 1'b0;

  // header checker model state, mirrors what the block keeps per packet
  logic [20:0] hc_sum;
  logic [4:0]  hc_words;
  logic [5:0]  hc_hdr_bytes;
  logic [15:0] hc_total_len;
  logic [15:0] hc_frame_len;
  logic [7:0]  hc_protocol;
  logic        hc_idle = 1'b1;

  // ---------------------------------------------------------------------------
  // header checker model: takes one accepted item, says whether a verdict item
  // comes out of it and what it holds
  // ---------------------------------------------------------------------------
  task automatic check_header_word(input ihc_item_t it, output bit got,
                                   output ihc_result_t r);
    logic [16:0] fold;
    logic [2:0]  v;
    got = 1'b0;
    r = '0;
    v = VERDICT_OK;
    if (it.first_word) begin
      // a first word always restarts, abandoning any unfinished packet
      hc_sum = '0;
      hc_words = '0;
      hc_hdr_bytes = '0;
      hc_total_len = '0;
      hc_protocol = '0;
      hc_frame_len = it.frame_bytes;
      hc_idle = 1'b0;
      // early checks, in priority order
      if (it.for_other_host) begin
        got = 1'b1;
        v = VERDICT_OTHER_HOST;
      end else if (it.frame_bytes < MIN_FRAME) begin
        got = 1'b1;
        v = VERDICT_TOO_SMALL;
      end else if (it.header_word[15:12] != IPV4_VERSION) begin
        got = 1'b1;
        v = VERDICT_NOT_V4;
      end else begin
        hc_hdr_bytes = {it.header_word[11:8], 2'b00};
        if (hc_hdr_bytes < MIN_IP_HEADER_BYTES) begin
          got = 1'b1;
          v = VERDICT_SHORT_HEADER;
        end
      end
    end else if (hc_idle) begin
      // nothing open, or verdict already given: word dropped
      return;
    end

    if (!got) begin
      if (hc_words == TOTAL_LEN_WORD) hc_total_len = it.header_word;
      if (hc_words == PROTOCOL_WORD) hc_protocol = it.header_word[7:0];
      hc_sum = hc_sum + it.header_word;
      hc_words = hc_words + 5'd1;
      if (hc_words == hc_hdr_bytes[5:1]) begin
        // header complete: fold twice, then checksum before length
        fold = {1'b0, hc_sum[15:0]} + hc_sum[20:16];
        fold = {1'b0, fold[15:0]} + fold[16];
        got = 1'b1;
        if (fold[15:0] != CHECKSUM_GOOD)
          v = VERDICT_CHECKSUM;
        else if (hc_total_len < hc_hdr_bytes ||
                 hc_frame_len < LINK_HEADER_BYTES + hc_total_len)
          v = VERDICT_LENGTH;
        else
          v = VERDICT_OK;
      end else if (it.last_word) begin
        // packet ended before its header was complete
        got = 1'b1;
        v = VERDICT_TRUNCATED;
      end
    end

    if (got) begin
      hc_idle = 1'b1;
      r.verdict = v;
      if (v != VERDICT_OTHER_HOST && v != VERDICT_TOO_SMALL && v != VERDICT_NOT_V4)
        r.header_bytes = hc_hdr_bytes;
      r.total_length = hc_total_len;
      if (v == VERDICT_OK) begin
        r.needs_trim = hc_frame_len > LINK_HEADER_BYTES + hc_total_len;
        r.protocol_number = hc_protocol;
      end
    end
  endtask

  task automatic push_word(input logic [15:0] hw, input logic first, input logic last,
                           input logic [15:0] fb, input logic other);
    stim_t s;
    s = '0;
    s.item = '{hw, first, last, fb, other};
    stim_q.push_back(s);
    stim_words++;
  endtask

  task automatic push_pause();
    stim_t s;
    s = '0;
    s.hold = 1'b1;
    stim_q.push_back(s);
  endtask

  // ---------------------------------------------------------------------------
  // random packet builder; most packets are well-formed headers with a good
  // checksum and random content so that the length and trim checks get reached
  // ---------------------------------------------------------------------------
  task automatic queue_packet();
    logic [15:0]  w [30];
    logic [20:0]  acc;
    logic [16:0]  fold;
    int           kind, ihl, hdr_bytes, nw, sendn, extra, lc, i;
    int unsigned  tl, fb;
    logic         last;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      // stray word with no first flag, dropped unless a packet is still open
      push_word(16'($urandom), 1'b0, 1'($urandom_range(0, 1)), 16'($urandom),
                1'($urandom_range(0, 1)));
      return;
    end
    if (kind < 15) begin
      // lone first word with random early-check fields
      w[0] = 16'($urandom);
      if ($urandom_range(0, 1)) w[0][15:12] = IPV4_VERSION;
      fb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MIN_FRAME - 1)
                                       : $urandom_range(0, 65535);
      push_word(w[0], 1'b1, 1'($urandom_range(0, 1)), fb[15:0], $urandom_range(0, 3) == 0);
      return;
    end

    // mostly minimal headers, some with options up to the largest ihl
    ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(6, 15);
    nw = ihl * 2;
    hdr_bytes = ihl * 4;
    for (i = 0; i < nw; i++) w[i] = 16'($urandom);
    w[0][15:8] = {IPV4_VERSION, ihl[3:0]};

    // total length against frame length: exact, trimmed, too short, too long, huge
    lc = $urandom_range(0, 9);
    if (lc < 5) begin
      tl = hdr_bytes + $urandom_range(0, 1480);
      fb = LINK_HEADER_BYTES + tl;
    end else if (lc < 7) begin
      tl = hdr_bytes + $urandom_range(0, 1480);
      fb = LINK_HEADER_BYTES + tl + $urandom_range(1, 64);
    end else if (lc == 7) begin
      tl = $urandom_range(0, hdr_bytes - 1);
      fb = $urandom_range(MIN_FRAME, 65535);
    end else if (lc == 8) begin
      tl = $urandom_range(hdr_bytes + 1, 65535);
      fb = $urandom_range(MIN_FRAME, (tl + LINK_HEADER_BYTES - 1 > 65535) ? 65535
                                      : tl + LINK_HEADER_BYTES - 1);
    end else begin
      tl = $urandom_range(hdr_bytes, 65535 - LINK_HEADER_BYTES);
      fb = $urandom_range(0, 1) ? LINK_HEADER_BYTES + tl : 65535;
    end
    w[1] = tl[15:0];

    // checksum word so that the folded sum comes to all ones
    w[5] = '0;
    acc = '0;
    for (i = 0; i < nw; i++) acc = acc + w[i];
    fold = {1'b0, acc[15:0]} + acc[20:16];
    fold = {1'b0, fold[15:0]} + fold[16];
    w[5] = ~fold[15:0];

    sendn = nw;
    extra = $urandom_range(0, 3);
    if (kind < 25) begin
      // single bit error somewhere past the first word
      i = $urandom_range(1, nw - 1);
      w[i] = w[i] ^ (16'h1 << $urandom_range(0, 15));
    end else if (kind < 42) begin
      // cut short: with a last flag (truncated) or without (abandoned by the next first)
      sendn = $urandom_range(1, nw - 1);
      extra = 0;
    end

    for (i = 0; i < sendn + extra; i++) begin
      if (kind >= 35 && kind < 42) last = 1'b0;
      else last = (i == sendn + extra - 1);
      if (i == 0)
        push_word(w[0], 1'b1, last, fb[15:0], 1'b0);
      else
        push_word((i < sendn) ? w[i] : 16'($urandom), 1'b0, last, 16'($urandom),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // both stream sides in one clocked process, so push and pop of the verdict
  // store never race each other
  // ---------------------------------------------------------------------------
  stim_t cur;
  int    burst_left = 1;
  int    gap_left = 0;
  int    rdy_left = 0;
  logic  rdy_on = 1'b0;

  task automatic report_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t verdict item mismatch on %s: expected 0x%0h, actual 0x%0h",
               $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : stream_side
    ihc_result_t seen, want, pred;
    bit          got;
    if (rst_n) begin
      // result side: compare with the oldest waiting verdict
      if (out_tvalid && out_tready) begin
        seen.verdict         = out_tdata[2:0];
        seen.header_bytes    = out_tdata[8:3];
        seen.total_length    = out_tdata[24:9];
        seen.needs_trim      = out_tdata[25];
        seen.protocol_number = out_tdata[33:26];
        if (verdict_q.size() == 0) begin
          $display("%0t verdict item with none expected: expected nothing, actual 0x%0h",
                   $time, out_tdata);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          report_field("verdict", want.verdict, seen.verdict);
          report_field("header_bytes", want.header_bytes, seen.header_bytes);
          report_field("total_length", want.total_length, seen.total_length);
          report_field("needs_trim", want.needs_trim, seen.needs_trim);
          report_field("protocol_number", want.protocol_number, seen.protocol_number);
        end
      end

      // receiver: ready runs and stall runs of random length, now and then long
      if (rdy_left == 0) begin
        rdy_on = !rdy_on;
        if (rdy_on)
          rdy_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        else
          rdy_left = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 6);
      end
      rdy_left--;
      out_tready <= rdy_on;

      // input side: model each accepted item
      if (in_tvalid && in_tready) begin
        check_header_word(cur.item, got, pred);
        if (cur.typed) verdict_q.push_back(cur.want);
        else if (got) verdict_q.push_back(pred);
      end

      // sender: bursts with gaps, and a hold until every verdict is back
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() != 0 && stim_q[0].hold) begin
          in_tvalid <= 1'b0;
          if (verdict_q.size() == 0) stim_q.delete(0);
        end else if (stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          in_tdata  <= {cur.item.frame_bytes, cur.item.header_word};
          in_tuser  <= {cur.item.for_other_host, cur.item.first_word};
          in_tlast  <= cur.item.last_word;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ipv4_header_ingress_checker] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table, then random packets, then drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    directed_rows = '{
      // stray word while idle: dropped
      '{'{16'hffff, 1'b0, 1'b1, 16'hffff, 1'b1}, 1'b0, '0, 1'b0},
      // other host wins over too small and bad version
      '{'{16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1}, 1'b1,
        '{VERDICT_OTHER_HOST, 6'd0, 16'd0, 1'b0, 8'd0}, 1'b0},
      // one byte below the smallest frame, wins over bad version
      '{'{16'hffff, 1'b1, 1'b1, 16'd33, 1'b0}, 1'b1,
        '{VERDICT_TOO_SMALL, 6'd0, 16'd0, 1'b0, 8'd0}, 1'b0},
      '{'{16'h6fff, 1'b1, 1'b0, 16'd34, 1'b0}, 1'b1,
        '{VERDICT_NOT_V4, 6'd0, 16'd0, 1'b0, 8'd0}, 1'b0},
      '{'{16'h4400, 1'b1, 1'b0, 16'hffff, 1'b0}, 1'b1,
        '{VERDICT_SHORT_HEADER, 6'd16, 16'd0, 1'b0, 8'd0}, 1'b0},
      '{'{16'h40ff, 1'b1, 1'b0, 16'd34, 1'b0}, 1'b1,
        '{VERDICT_SHORT_HEADER, 6'd0, 16'd0, 1'b0, 8'd0}, 1'b0},
      // single-word packet
      '{'{16'h4500, 1'b1, 1'b1, 16'd34, 1'b0}, 1'b1,
        '{VERDICT_TRUNCATED, 6'd20, 16'd0, 1'b0, 8'd0}, 1'b0},
      // open a packet, restart it at the largest ihl, end it on word two
      '{'{16'h45ff, 1'b1, 1'b0, 16'h0100, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'h4f00, 1'b1, 1'b0, 16'h0100, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'hffff, 1'b0, 1'b1, 16'hffff, 1'b1}, 1'b1,
        '{VERDICT_TRUNCATED, 6'd60, 16'hffff, 1'b0, 8'd0}, 1'b0},
      // textbook udp header with a good checksum, frame exactly 14 + total length
      '{'{16'h4500, 1'b1, 1'b0, 16'd129, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'h0073, 1'b0, 1'b0, 16'h0000, 1'b1}, 1'b0, '0, 1'b0},
      '{'{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'h4000, 1'b0, 1'b0, 16'hffff, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'h4011, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'hb861, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'hc0a8, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'hc0a8, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0, 1'b0},
      '{'{16'h00c7, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b1,
        '{VERDICT_OK, 6'd20, 16'd115, 1'b0, 8'h11}, 1'b0},
      // payload word after the verdict: dropped
      '{'{16'h1234, 1'b0, 1'b1, 16'h0000, 1'b1}, 1'b0, '0, 1'b0}
    };
    foreach (directed_rows[i]) begin
      stim_q.push_back(directed_rows[i]);
      stim_words++;
    end
    push_pause();

    while (stim_words < RANDOM_WORDS) begin
      queue_packet();
      // one more full drain somewhere in the middle of the random run
      if (!mid_drained && stim_words >= RANDOM_WORDS / 2) begin
        push_pause();
        mid_drained = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sampled on the falling edge so that all rising-edge updates have settled
    while (stim_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t verdict items missing: expected %0d more, actual 0",
               $time, verdict_q.size());
      errors++;
    end

    if (errors == 0)
      $display("[ipv4_header_ingress_checker] OK");
    else
      $display("[ipv4_header_ingress_checker] ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ihc_pkg.sv
hw/rtl/ihc_step.sv
hw/rtl/ipv4_header_ingress_checker.sv
hw/rtl/ihc_checker.sv
tb/sv/ipv4_header_ingress_checker_test.sv
